>>> rtl/core/sts_pkg.sv
package sts_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = FRAC_BITS + 2;
    localparam int VERT_W    = 3 * COORD_W;
    localparam int WIDE_W    = 39;
    localparam int MAG_W     = 30;
    localparam int LEN_W     = 62;
    localparam int REM_W     = 48;
    localparam int QUO_W     = 18;
    localparam int DIV_STEPS = 18;
    localparam int SQRT_LAST = 30;
    localparam int LVL_W     = 2;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 216;

    localparam logic CFG_DEPTH = 1'b0;
    localparam logic CFG_FLAT  = 1'b1;

    localparam logic RET_MID = 1'b0;
    localparam logic RET_NRM = 1'b1;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_NODE  = 13'b0000000000010,
        S_MID   = 13'b0000000000100,
        S_CROSS = 13'b0000000001000,
        S_UMAG  = 13'b0000000010000,
        S_UNORM = 13'b0000000100000,
        S_USQ   = 13'b0000001000000,
        S_USQRT = 13'b0000010000000,
        S_UDIV  = 13'b0000100000000,
        S_UDONE = 13'b0001000000000,
        S_CHILD = 13'b0010000000000,
        S_EMIT  = 13'b0100000000000,
        S_POP   = 13'b1000000000000
    } state_t;

    function automatic logic signed [COORD_W-1:0] coord_of(logic [VERT_W-1:0] p, int k);
        coord_of = p[(2 - k) * COORD_W +: COORD_W];
    endfunction

endpackage

>>> rtl/core/sphere_triangle_subdivider_top.sv
// Splits one triangle of unit vectors subdivision_depth times (0..MAX_DEPTH) and streams
// out the 4^depth leaf triangles depth-first, the final one with tlast. Each input beat
// is taken only while the block is idle. All arithmetic goes through one shared
// sequencer with a single multiplier, a one-bit-per-cycle normalizing shifter, a
// restoring square root and a restoring divider that works one coordinate at a time.
// Midpoints are computed once per inner node (3 per node, 21 nodes at depth 3), and
// flat mode adds one unit-vector operation per leaf. The walk holds while the output
// is stalled. Configuration beats are always accepted.
module sphere_triangle_subdivider_top #(
    parameter int MAX_DEPTH = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // corner_a, corner_b, corner_c, zero pad
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_corner_a, out_corner_b, out_corner_c, face_normal
    output logic [215:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [1:0]   cfg_data
);

    localparam int MID_N  = (MAX_DEPTH > 0) ? MAX_DEPTH : 1;
    localparam int STK_N  = 3 * (MAX_DEPTH + 1);
    localparam int STK_IW = $clog2(STK_N);
    localparam int MID_IW = (3 * MID_N > 1) ? $clog2(3 * MID_N) : 1;
    localparam int POS_IW = (MID_N > 1) ? $clog2(MID_N) : 1;
    localparam int VW = sts_pkg::VERT_W;
    localparam int CW = sts_pkg::COORD_W;
    localparam int WW = sts_pkg::WIDE_W;

    sts_pkg::state_t state_reg;
    logic [VW-1:0] stk_reg [STK_N];
    logic [VW-1:0] mid_reg [3*MID_N];
    logic [1:0] pos_reg [MID_N];
    logic [sts_pkg::LVL_W-1:0] lvl_reg;
    logic [1:0] midx_reg;
    logic [1:0] depth_reg;
    logic flat_reg;
    logic ret_reg;
    logic signed [WW-1:0] v_reg [3];
    logic [WW-1:0] mag_reg [3];
    logic [2:0] neg_reg;
    logic [2:0] cnt_reg;
    logic [sts_pkg::LEN_W-1:0] len_reg;
    logic [sts_pkg::LEN_W-1:0] root_reg;
    logic [4:0] it_reg;
    logic [1:0] k_reg;
    logic [sts_pkg::REM_W-1:0] rem_reg;
    logic [sts_pkg::REM_W-1:0] dv_reg;
    logic [sts_pkg::QUO_W-1:0] q_reg;
    logic [VW-1:0] res_reg;
    logic [VW-1:0] out_a_reg, out_b_reg, out_c_reg, out_n_reg;
    logic out_last_reg;

    logic [1:0] eff_depth;
    logic [STK_IW-1:0] cur_base, child_base;
    logic [VW-1:0] ta, tb, tc;
    logic [sts_pkg::LVL_W-1:0] plvl;
    logic [STK_IW-1:0] pbase;
    logic [MID_IW-1:0] pmbase, cmbase;
    logic [VW-1:0] pa, pb, pc, pab, pbc, pca;
    logic [1:0] cidx;
    logic signed [CW:0] d1 [3];
    logic signed [CW:0] d2 [3];
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic [WW-1:0] m_max;
    logic [sts_pkg::LEN_W-1:0] bitv, trial;
    logic [30:0] dval;
    logic [sts_pkg::QUO_W-1:0] qn;
    logic [sts_pkg::QUO_W-2:0] qsat;
    logic [CW-1:0] coord_res;
    logic last_flag;

    assign eff_depth = (depth_reg > 2'(MAX_DEPTH)) ? 2'(MAX_DEPTH) : depth_reg;
    assign cur_base = STK_IW'(lvl_reg * 3);
    assign ta = stk_reg[cur_base];
    assign tb = stk_reg[cur_base + STK_IW'(1)];
    assign tc = stk_reg[cur_base + STK_IW'(2)];

    assign plvl = (state_reg == sts_pkg::S_POP) ? lvl_reg - 2'd1 : lvl_reg;
    assign pbase = STK_IW'(plvl * 3);
    assign pmbase = MID_IW'(plvl * 3);
    assign cmbase = MID_IW'(lvl_reg * 3);
    assign child_base = STK_IW'((plvl + 3'd1) * 3);
    assign pa = stk_reg[pbase];
    assign pb = stk_reg[pbase + STK_IW'(1)];
    assign pc = stk_reg[pbase + STK_IW'(2)];
    assign pab = mid_reg[pmbase];
    assign pbc = mid_reg[pmbase + MID_IW'(1)];
    assign pca = mid_reg[pmbase + MID_IW'(2)];
    assign cidx = (state_reg == sts_pkg::S_POP) ? pos_reg[plvl[POS_IW-1:0]] + 2'd1 : 2'd0;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d1[k] = (CW+1)'(sts_pkg::coord_of(ta, k)) - (CW+1)'(sts_pkg::coord_of(tb, k));
            d2[k] = (CW+1)'(sts_pkg::coord_of(tb, k)) - (CW+1)'(sts_pkg::coord_of(tc, k));
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == sts_pkg::S_CROSS)
        begin
            case (cnt_reg)
                3'd0:
                begin
                    mul_a = 32'(d1[1]); mul_b = 32'(d2[2]);
                end
                3'd1:
                begin
                    mul_a = 32'(d1[2]); mul_b = 32'(d2[1]);
                end
                3'd2:
                begin
                    mul_a = 32'(d1[2]); mul_b = 32'(d2[0]);
                end
                3'd3:
                begin
                    mul_a = 32'(d1[0]); mul_b = 32'(d2[2]);
                end
                3'd4:
                begin
                    mul_a = 32'(d1[0]); mul_b = 32'(d2[1]);
                end
                default:
                begin
                    mul_a = 32'(d1[1]); mul_b = 32'(d2[0]);
                end
            endcase
        end
        else
        begin
            mul_a = {2'b00, mag_reg[cnt_reg[1:0]][sts_pkg::MAG_W-1:0]};
            mul_b = {2'b00, mag_reg[cnt_reg[1:0]][sts_pkg::MAG_W-1:0]};
        end
    end
    assign prod = mul_a * mul_b;

    always_comb
    begin
        m_max = mag_reg[0];
        if (mag_reg[1] > m_max)
        begin
            m_max = mag_reg[1];
        end
        if (mag_reg[2] > m_max)
        begin
            m_max = mag_reg[2];
        end
    end

    assign bitv = sts_pkg::LEN_W'(1) << (6'd60 - {it_reg, 1'b0});
    assign trial = root_reg + bitv;
    assign dval = root_reg[30:0];
    assign qn = {q_reg[sts_pkg::QUO_W-2:0], (rem_reg >= dv_reg)};
    assign qsat = qn[sts_pkg::QUO_W-1] ? '1 : qn[sts_pkg::QUO_W-2:0];
    assign coord_res = neg_reg[k_reg] ? CW'(-{1'b0, qsat}) : CW'({1'b0, qsat});

    always_comb
    begin
        last_flag = 1'b1;
        for (int i = 0; i < MID_N; i++)
        begin
            if ((i < int'(lvl_reg)) && (pos_reg[i] != 2'd3))
            begin
                last_flag = 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == sts_pkg::S_IDLE);
    assign m_tvalid = (state_reg == sts_pkg::S_EMIT);
    assign m_tdata = {out_n_reg, out_c_reg, out_b_reg, out_a_reg};
    assign m_tlast = out_last_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= 2'd0;
            flat_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sts_pkg::CFG_DEPTH: depth_reg <= cfg_data;
                sts_pkg::CFG_FLAT:  flat_reg <= cfg_data[0];
                default:            depth_reg <= depth_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == sts_pkg::S_IDLE) && s_tvalid)
        begin
            stk_reg[0] <= s_tdata[VW-1:0];
            stk_reg[1] <= s_tdata[2*VW-1:VW];
            stk_reg[2] <= s_tdata[3*VW-1:2*VW];
        end
        else if ((state_reg == sts_pkg::S_CHILD) ||
                 ((state_reg == sts_pkg::S_POP) && (lvl_reg != '0) &&
                  (pos_reg[plvl[POS_IW-1:0]] != 2'd3)))
        begin
            case (cidx)
                2'd0:
                begin
                    stk_reg[child_base] <= pa;
                    stk_reg[child_base + STK_IW'(1)] <= pab;
                    stk_reg[child_base + STK_IW'(2)] <= pca;
                end
                2'd1:
                begin
                    stk_reg[child_base] <= pb;
                    stk_reg[child_base + STK_IW'(1)] <= pbc;
                    stk_reg[child_base + STK_IW'(2)] <= pab;
                end
                2'd2:
                begin
                    stk_reg[child_base] <= pc;
                    stk_reg[child_base + STK_IW'(1)] <= pca;
                    stk_reg[child_base + STK_IW'(2)] <= pbc;
                end
                default:
                begin
                    stk_reg[child_base] <= pab;
                    stk_reg[child_base + STK_IW'(1)] <= pbc;
                    stk_reg[child_base + STK_IW'(2)] <= pca;
                end
            endcase
        end
        if ((state_reg == sts_pkg::S_UDONE) && (ret_reg == sts_pkg::RET_MID))
        begin
            mid_reg[cmbase + MID_IW'(midx_reg)] <= res_reg;
        end
    end

    // datapath of the shared unit
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sts_pkg::S_MID:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    case (midx_reg)
                        2'd0:    v_reg[k] <= WW'(sts_pkg::coord_of(ta, k)) +
                                             WW'(sts_pkg::coord_of(tb, k));
                        2'd1:    v_reg[k] <= WW'(sts_pkg::coord_of(tb, k)) +
                                             WW'(sts_pkg::coord_of(tc, k));
                        default: v_reg[k] <= WW'(sts_pkg::coord_of(tc, k)) +
                                             WW'(sts_pkg::coord_of(ta, k));
                    endcase
                end
                cnt_reg <= 3'd0;
            end
            sts_pkg::S_NODE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    v_reg[k] <= '0;
                end
                cnt_reg <= 3'd0;
                res_reg <= '0;
            end
            sts_pkg::S_CROSS:
            begin
                if (cnt_reg[0])
                begin
                    v_reg[cnt_reg[2:1]] <= v_reg[cnt_reg[2:1]] - WW'(prod);
                end
                else
                begin
                    v_reg[cnt_reg[2:1]] <= v_reg[cnt_reg[2:1]] + WW'(prod);
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
            sts_pkg::S_UMAG:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    neg_reg[k] <= v_reg[k][WW-1];
                    mag_reg[k] <= v_reg[k][WW-1] ? WW'(-v_reg[k]) : WW'(v_reg[k]);
                end
            end
            sts_pkg::S_UNORM:
            begin
                if (m_max == '0)
                begin
                    res_reg <= '0;
                end
                else if (m_max[WW-1:sts_pkg::MAG_W] != '0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[k] <= mag_reg[k] >> 1;
                    end
                end
                else if (!m_max[sts_pkg::MAG_W-1])
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[k] <= mag_reg[k] << 1;
                    end
                end
                len_reg <= '0;
                cnt_reg <= 3'd0;
            end
            sts_pkg::S_USQ:
            begin
                len_reg <= len_reg + sts_pkg::LEN_W'(prod);
                cnt_reg <= cnt_reg + 3'd1;
                root_reg <= '0;
                it_reg <= 5'd0;
            end
            sts_pkg::S_USQRT:
            begin
                if (len_reg >= trial)
                begin
                    len_reg <= len_reg - trial;
                    root_reg <= (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                it_reg <= (it_reg == 5'(sts_pkg::SQRT_LAST)) ? 5'd0 : it_reg + 5'd1;
                k_reg <= 2'd0;
            end
            sts_pkg::S_UDIV:
            begin
                if (it_reg == 5'd0)
                begin
                    rem_reg <= {2'b00, mag_reg[k_reg][sts_pkg::MAG_W-1:0], 16'b0} +
                               sts_pkg::REM_W'(dval >> 1);
                    dv_reg <= {dval, 17'b0};
                    q_reg <= '0;
                    it_reg <= 5'd1;
                end
                else
                begin
                    if (rem_reg >= dv_reg)
                    begin
                        rem_reg <= rem_reg - dv_reg;
                    end
                    dv_reg <= dv_reg >> 1;
                    q_reg <= qn;
                    if (it_reg == 5'(sts_pkg::DIV_STEPS))
                    begin
                        res_reg[(2 - k_reg) * CW +: CW] <= coord_res;
                        k_reg <= k_reg + 2'd1;
                        it_reg <= 5'd0;
                    end
                    else
                    begin
                        it_reg <= it_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (((state_reg == sts_pkg::S_UDONE) && (ret_reg == sts_pkg::RET_NRM)) ||
            ((state_reg == sts_pkg::S_NODE) && (lvl_reg >= eff_depth) && !flat_reg))
        begin
            out_a_reg <= ta;
            out_b_reg <= tb;
            out_c_reg <= tc;
            out_n_reg <= (state_reg == sts_pkg::S_NODE) ? '0 : res_reg;
            out_last_reg <= last_flag;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::S_IDLE;
            lvl_reg <= '0;
            midx_reg <= 2'd0;
            ret_reg <= sts_pkg::RET_MID;
            for (int i = 0; i < MID_N; i++)
            begin
                pos_reg[i] <= 2'd0;
            end
        end
        else
        begin
            case (state_reg)
                sts_pkg::S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        lvl_reg <= '0;
                        state_reg <= sts_pkg::S_NODE;
                    end
                end
                sts_pkg::S_NODE:
                begin
                    if (lvl_reg < eff_depth)
                    begin
                        midx_reg <= 2'd0;
                        pos_reg[lvl_reg[POS_IW-1:0]] <= 2'd0;
                        state_reg <= sts_pkg::S_MID;
                    end
                    else if (flat_reg)
                    begin
                        state_reg <= sts_pkg::S_CROSS;
                    end
                    else
                    begin
                        state_reg <= sts_pkg::S_EMIT;
                    end
                end
                sts_pkg::S_MID:
                begin
                    ret_reg <= sts_pkg::RET_MID;
                    state_reg <= sts_pkg::S_UMAG;
                end
                sts_pkg::S_CROSS:
                begin
                    if (cnt_reg == 3'd5)
                    begin
                        ret_reg <= sts_pkg::RET_NRM;
                        state_reg <= sts_pkg::S_UMAG;
                    end
                end
                sts_pkg::S_UMAG:
                begin
                    state_reg <= sts_pkg::S_UNORM;
                end
                sts_pkg::S_UNORM:
                begin
                    if (m_max == '0)
                    begin
                        state_reg <= sts_pkg::S_UDONE;
                    end
                    else if ((m_max[WW-1:sts_pkg::MAG_W] == '0) && m_max[sts_pkg::MAG_W-1])
                    begin
                        state_reg <= sts_pkg::S_USQ;
                    end
                end
                sts_pkg::S_USQ:
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        state_reg <= sts_pkg::S_USQRT;
                    end
                end
                sts_pkg::S_USQRT:
                begin
                    if (it_reg == 5'(sts_pkg::SQRT_LAST))
                    begin
                        state_reg <= sts_pkg::S_UDIV;
                    end
                end
                sts_pkg::S_UDIV:
                begin
                    if ((it_reg == 5'(sts_pkg::DIV_STEPS)) && (k_reg == 2'd2))
                    begin
                        state_reg <= sts_pkg::S_UDONE;
                    end
                end
                sts_pkg::S_UDONE:
                begin
                    if (ret_reg == sts_pkg::RET_NRM)
                    begin
                        state_reg <= sts_pkg::S_EMIT;
                    end
                    else if (midx_reg == 2'd2)
                    begin
                        state_reg <= sts_pkg::S_CHILD;
                    end
                    else
                    begin
                        midx_reg <= midx_reg + 2'd1;
                        state_reg <= sts_pkg::S_MID;
                    end
                end
                sts_pkg::S_CHILD:
                begin
                    lvl_reg <= lvl_reg + 2'd1;
                    state_reg <= sts_pkg::S_NODE;
                end
                sts_pkg::S_EMIT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= sts_pkg::S_POP;
                    end
                end
                sts_pkg::S_POP:
                begin
                    if (lvl_reg == '0)
                    begin
                        state_reg <= sts_pkg::S_IDLE;
                    end
                    else if (pos_reg[plvl[POS_IW-1:0]] == 2'd3)
                    begin
                        lvl_reg <= lvl_reg - 2'd1;
                    end
                    else
                    begin
                        pos_reg[plvl[POS_IW-1:0]] <= cidx;
                        state_reg <= sts_pkg::S_NODE;
                    end
                end
                default:
                begin
                    state_reg <= sts_pkg::S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/sts_checker.sv
module sts_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [167:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [215:0] m_tdata,
    input logic         m_tlast,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic         cfg_index,
    input logic [1:0]   cfg_data
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // one triangle at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("ready for input while a result is pending");

    // more leaves follow unless the beat was the last
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("walk ended before last leaf");

endmodule

bind sphere_triangle_subdivider_top sts_checker u_sts_checker (.*);
